// ----- design/quoted_printable_encoder_core_defines.svh -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_ENCODER_CORE_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked property on clk, disabled while rst is high.
`define QPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true at a clock edge.
`define QPE_NEVER(lbl, cond, msg) `QPE_ASSERT(lbl, !(cond), msg)
`else
`define QPE_ASSERT(lbl, prop, msg)
`define QPE_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/qpe_pkg.sv -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder package
// Job descriptor type, character constants and small helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package qpe_pkg;

  // What the body of a job emits after the optional escaped CR and soft break.
  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_PASS,
    BODY_ESC,
    BODY_CRLF
  } body_t;

  typedef struct packed {
    logic       esc_cr;  // emit =0D first
    logic       brk;     // emit soft break = CR LF next
    body_t      body;
    logic [7:0] data;
  } job_t;

  localparam logic [7:0] LIMIT_RESET = 8'd68;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam int         QUEUE_DEPTH = 2;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return CH_ZERO + {4'b0, v};
    end else begin
      return 8'h37 + {4'b0, v};
    end
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [1:0] n);
    logic [8:0] s;
    s = {1'b0, c} + {7'b0, n};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    return b inside {[8'd33:8'd60], [8'd62:8'd126]};
  endfunction

  // Segments still to send: bit 0 escaped CR, bit 1 soft break, bit 2 body.
  function automatic logic [2:0] job_mask(input job_t j);
    return {j.body != BODY_NONE, j.brk, j.esc_cr};
  endfunction

endpackage

`default_nettype wire

// ----- design/qpe_in_if.sv -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder input channel
// Valid/ready channel carrying one raw byte or an end-of-stream mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface qpe_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source(output valid, output opcode, output data_byte, input ready);
  modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- design/qpe_out_if.sv -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder output channel
// Valid/ready channel carrying one encoded byte and its last flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface qpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source(output valid, output out_byte, output last, input ready);
  modport sink(input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- design/quoted_printable_encoder_core.sv -----
// Usage of quoted_printable_encoder_core:
//  in_ch  (valid/ready): opcode 0 carries a raw byte in data_byte, opcode 1
//         marks end of stream and flushes a held CR and a final soft break.
//  out_ch (valid/ready): one encoded ASCII byte per transfer; last is high on
//         the final byte caused by one input item. Items that cause no bytes
//         (a CR with no CR held or break due, an idle end of stream) give none.
//  cfg_we/cfg_wdata: write line_limit (reset 68); write only while idle.
// The first output byte of an item passes the job queue and then the output
//  register before it is valid. The back end sends one byte per cycle while
//  out_ch is not stalled; an item produces 1 byte for plain text,
//  3 for an escape, up to 9 for a held CR, a soft break and an escape.
//  Input is taken every cycle while the two-entry job queue has room.
// Reset (rst, synchronous): clears line length, held CR, queue and output.
// A stall on out_ch holds the output register; the queue then fills and
//  in_ch.ready drops.
// ---------------------------------------------------------------------------
// Quoted-printable encoder core
// Top level: line limit register, front end, job queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module quoted_printable_encoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  qpe_in_if.sink          in_ch,
  qpe_out_if.source       out_ch
);

  // Soft break goes in before a character once the line is longer than this
  logic [7:0] line_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= qpe_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit <= cfg_wdata;
    end
  end

  // Job handoff between the front end and the back end
  logic          push, pop, q_full, q_not_empty;
  qpe_pkg::job_t push_job, head;

  // Classify each item and update the line state at its transfer
  qpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .line_limit (line_limit),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Decouple classification from byte output
  qpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Expand jobs into bytes, one transfer per cycle while out_ch is not stalled
  qpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- design/qpe_front.sv -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder front end
// Accepts items, tracks line length and held CR, and builds output jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module qpe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    line_limit,
  qpe_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               push,
  output qpe_pkg::job_t      push_job
);

  logic       line_count, cr_pending;
  logic [7:0] line_count_r, line_count_next;
  logic       cr_pending_r;
  logic       cr_pending_next;
  logic       accept;
  logic [7:0] c0, c1;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign line_count  = |line_count_r;
  assign cr_pending  = cr_pending_r;

  // Length after a held CR is flushed as =0D
  assign c0 = cr_pending_r ? qpe_pkg::sat_add(line_count_r, 2'd3) : line_count_r;

  always_comb begin
    push_job        = '0;
    push_job.body   = qpe_pkg::BODY_NONE;
    push_job.data   = in_ch.data_byte;
    line_count_next = line_count_r;
    cr_pending_next = cr_pending_r;
    c1              = c0;
    if (in_ch.opcode) begin
      push_job.esc_cr = cr_pending_r;
      push_job.brk    = c0 != 8'd0;
      line_count_next = 8'd0;
      cr_pending_next = 1'b0;
    end else if (cr_pending_r && in_ch.data_byte == qpe_pkg::CH_LF) begin
      push_job.body   = qpe_pkg::BODY_CRLF;
      line_count_next = 8'd0;
      cr_pending_next = 1'b0;
    end else begin
      push_job.esc_cr = cr_pending_r;
      push_job.brk    = c0 > line_limit;
      c1              = push_job.brk ? 8'd0 : c0;
      cr_pending_next = 1'b0;
      if (qpe_pkg::is_plain(in_ch.data_byte)) begin
        push_job.body   = qpe_pkg::BODY_PASS;
        line_count_next = qpe_pkg::sat_add(c1, 2'd1);
      end else if (in_ch.data_byte == qpe_pkg::CH_CR) begin
        line_count_next = c1;
        cr_pending_next = 1'b1;
      end else begin
        push_job.body   = qpe_pkg::BODY_ESC;
        line_count_next = qpe_pkg::sat_add(c1, 2'd3);
      end
    end
  end

  // Drop jobs that emit nothing
  assign push = accept && (qpe_pkg::job_mask(push_job) != 3'b000);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count_r <= 8'd0;
      cr_pending_r <= 1'b0;
    end else if (accept) begin
      line_count_r <= line_count_next;
      cr_pending_r <= cr_pending_next;
    end
  end

  `include "quoted_printable_encoder_core_defines.svh"

  `QPE_ASSERT(a_flush_clears, (accept && in_ch.opcode) |=> (!line_count && !cr_pending), "flush left state")

endmodule

`default_nettype wire

// ----- design/qpe_fifo.sv -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder job queue
// Two-entry queue of job descriptors between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module qpe_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire qpe_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output qpe_pkg::job_t      head
);

  localparam int PTR_W = $clog2(qpe_pkg::QUEUE_DEPTH);

  qpe_pkg::job_t     mem [qpe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;

  assign full      = count == (PTR_W + 1)'(qpe_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `include "quoted_printable_encoder_core_defines.svh"

  `QPE_NEVER(a_no_overflow, push && full, "job queue overflow")
  `QPE_NEVER(a_no_underflow, pop && !not_empty, "job queue underflow")

endmodule

`default_nettype wire

// ----- design/qpe_back.sv -----
// ---------------------------------------------------------------------------
// Quoted-printable encoder back end
// Expands jobs into encoded bytes, one per cycle unless stalled, into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module qpe_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          not_empty,
  input  wire qpe_pkg::job_t head,
  output logic               pop,
  qpe_out_if.source          out_ch
);

  logic          busy;
  qpe_pkg::job_t cur;
  logic [2:0]    cur_mask;
  logic [1:0]    idx;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_last;

  qpe_pkg::job_t src;
  logic [2:0]    src_mask, seg_bit, rest_mask;
  logic [1:0]    src_idx, seg_len;
  logic          src_valid, slot_free, emit, seg_end, final_byte;
  logic [7:0]    byte_val;

  assign src       = busy ? cur : head;
  assign src_mask  = busy ? cur_mask : qpe_pkg::job_mask(head);
  assign src_idx   = busy ? idx : 2'd0;
  assign src_valid = busy || not_empty;
  assign slot_free = !out_valid || out_ch.ready;
  assign emit      = src_valid && slot_free;
  assign pop       = emit && !busy;

  // Lowest pending segment is the one being sent
  assign seg_bit   = src_mask & (~src_mask + 3'd1);
  assign rest_mask = src_mask & ~seg_bit;

  always_comb begin
    seg_len  = 2'd3;
    byte_val = qpe_pkg::CH_EQ;
    if (seg_bit[0]) begin
      case (src_idx)
        2'd1:    byte_val = qpe_pkg::CH_ZERO;
        2'd2:    byte_val = qpe_pkg::CH_D;
        default: byte_val = qpe_pkg::CH_EQ;
      endcase
    end else if (seg_bit[1]) begin
      case (src_idx)
        2'd1:    byte_val = qpe_pkg::CH_CR;
        2'd2:    byte_val = qpe_pkg::CH_LF;
        default: byte_val = qpe_pkg::CH_EQ;
      endcase
    end else begin
      case (src.body)
        qpe_pkg::BODY_PASS: begin
          seg_len  = 2'd1;
          byte_val = src.data;
        end
        qpe_pkg::BODY_CRLF: begin
          seg_len  = 2'd2;
          byte_val = (src_idx == 2'd0) ? qpe_pkg::CH_CR : qpe_pkg::CH_LF;
        end
        qpe_pkg::BODY_ESC: begin
          case (src_idx)
            2'd1:    byte_val = qpe_pkg::hex_digit(src.data[7:4]);
            2'd2:    byte_val = qpe_pkg::hex_digit(src.data[3:0]);
            default: byte_val = qpe_pkg::CH_EQ;
          endcase
        end
        default: begin
          seg_len  = 2'd1;
          byte_val = qpe_pkg::CH_EQ;
        end
      endcase
    end
  end

  assign seg_end    = src_idx == (seg_len - 2'd1);
  assign final_byte = seg_end && (rest_mask == 3'b000);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      busy      <= !final_byte;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_val;
      out_last <= final_byte;
      cur      <= src;
      cur_mask <= seg_end ? rest_mask : src_mask;
      idx      <= seg_end ? 2'd0 : src_idx + 2'd1;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

  `include "quoted_printable_encoder_core_defines.svh"

  `QPE_ASSERT(a_busy_has_work, busy |-> (cur_mask != 3'b000), "busy with empty job")

endmodule

`default_nettype wire
